FILE: rtl/cross_stencil_star_counter_unit_macros.svh
// Assertion macros for the cross stencil star counter.
`ifndef CROSS_STENCIL_STAR_COUNTER_UNIT_MACROS_SVH
`define CROSS_STENCIL_STAR_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define CSC_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define CSC_ASSERT_SAME(label, pre, post, msg)
`define CSC_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: rtl/csc_pkg.sv
// Shared constants and types of the cross stencil star counter.
package csc_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;

	localparam int PIXEL_W  = 8;
	localparam int THRESH_W = 11;
	localparam int SUM_W    = 11;
	localparam int COUNT_W  = 12;
	localparam int COL_W    = $clog2(FRAME_WIDTH);
	localparam int ROW_W    = $clog2(FRAME_HEIGHT);

	// the line chain holds the two previous rows
	localparam int CHAIN_LEN = 2 * FRAME_WIDTH;
	// taps, counted as items back minus one
	localparam int TAP_RIGHT  = FRAME_WIDTH - 2;
	localparam int TAP_CENTRE = FRAME_WIDTH - 1;
	localparam int TAP_LEFT   = FRAME_WIDTH;
	localparam int TAP_ABOVE  = 2 * FRAME_WIDTH - 1;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_THRESH = 1'b0;

	typedef logic [PIXEL_W-1:0]  pixel_t;
	typedef logic [THRESH_W-1:0] thresh_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [COL_W-1:0]    col_t;
	typedef logic [ROW_W-1:0]    row_t;

	localparam thresh_t THRESH_RESET = thresh_t'(30);
	localparam count_t  COUNT_MAX    = '1;

	// neighborhood seen by the stencil when the current pixel arrives
	typedef struct packed {
		pixel_t left;
		pixel_t centre;
		pixel_t right;
		pixel_t above;
	} taps_t;

endpackage

FILE: rtl/csc_cell.sv
// One pixel cell of the line chain: loads its neighbor's pixel on each item.
module csc_cell (
	input  logic            clk,
	input  logic            shift_en,
	input  csc_pkg::pixel_t din,
	output csc_pkg::pixel_t dout
);
	import csc_pkg::*;

	pixel_t pix_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			pix_q <= din;
		end
	end

	assign dout = pix_q;

endmodule

FILE: rtl/csc_line_chain.sv
// Chain of pixel cells spanning two rows, with the stencil taps.
module csc_line_chain (
	input  logic            clk,
	input  logic            shift_en,
	input  csc_pkg::pixel_t pixel,
	output csc_pkg::taps_t  taps
);
	import csc_pkg::*;

	pixel_t chain [CHAIN_LEN];

	generate
		for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
			if (k == 0) begin : g_head
				csc_cell u_cell (
					.clk      (clk),
					.shift_en (shift_en),
					.din      (pixel),
					.dout     (chain[k])
				);
			end else begin : g_body
				csc_cell u_cell (
					.clk      (clk),
					.shift_en (shift_en),
					.din      (chain[k-1]),
					.dout     (chain[k])
				);
			end
		end
	endgenerate

	// cell k holds the pixel k+1 items back
	assign taps.left   = chain[TAP_LEFT];
	assign taps.centre = chain[TAP_CENTRE];
	assign taps.right  = chain[TAP_RIGHT];
	assign taps.above  = chain[TAP_ABOVE];

endmodule

FILE: rtl/cross_stencil_star_counter_unit.sv
// Top level of the cross stencil star counter.
`include "cross_stencil_star_counter_unit_macros.svh"

// Takes one pixel per clock in raster order over a FRAME_WIDTH x FRAME_HEIGHT
// frame. When a pixel arrives, the cross centered one row above it is
// complete; its five-point sum is formed and compared with thresh_q in
// that same cycle, and the star count is updated at the accepting edge. Two
// rows of history live in a chain of 2*FRAME_WIDTH pixel cells that shifts
// once per item. The count (saturating at 4095) is presented on the result
// register when the frame's last pixel is accepted and cleared for the next
// frame. Sustained rate is one pixel per clock; pixel_ready drops only while
// the last pixel of a frame waits behind an untaken count. Pixel history is
// not cleared at reset; crosses are tested only from the third row on.
module cross_stencil_star_counter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel channel
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  csc_pkg::pixel_t             pixel,
	// star count channel
	output logic                        star_valid,
	input  logic                        star_ready,
	output csc_pkg::count_t             star_count,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csc_pkg::ADDR_W-1:0]  paddr,
	input  logic [csc_pkg::DATA_W-1:0]  pwdata,
	output logic [csc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import csc_pkg::*;

	thresh_t thresh_q;
	col_t    col_q;
	row_t    row_q;
	count_t  count_q;
	count_t  star_count_q;
	logic    star_valid_q;

	taps_t   taps;
	sum_t    cross_sum;
	logic    accept;
	logic    col_last;
	logic    row_last;
	logic    frame_last;
	logic    test_en;
	logic    hit;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESH) ? DATA_W'(thresh_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_THRESH) begin
			thresh_q <= pwdata[THRESH_W-1:0];
		end
	end

	// position and handshake
	assign col_last    = (col_q == col_t'(FRAME_WIDTH - 1));
	assign row_last    = (row_q == row_t'(FRAME_HEIGHT - 1));
	assign frame_last  = col_last && row_last;
	assign pixel_ready = !(star_valid_q && !star_ready && frame_last);
	assign accept      = pixel_valid && pixel_ready;

	csc_line_chain u_chain (
		.clk      (clk),
		.shift_en (accept),
		.pixel    (pixel),
		.taps     (taps)
	);

	assign test_en   = (row_q >= row_t'(2)) && (col_q != '0) && !col_last;
	assign cross_sum = sum_t'(taps.left) + sum_t'(taps.centre) + sum_t'(taps.right)
		+ sum_t'(taps.above) + sum_t'(pixel);
	assign hit       = test_en && (cross_sum > thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + row_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
			if (frame_last) begin
				count_q <= '0;
			end else if (hit && count_q != COUNT_MAX) begin
				count_q <= count_q + count_t'(1);
			end
		end
	end

	// result register; the last column never tests a cross, so count_q is final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_valid_q <= 1'b0;
		end else if (accept && frame_last) begin
			star_valid_q <= 1'b1;
		end else if (star_ready) begin
			star_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_last) begin
			star_count_q <= count_q;
		end
	end

	assign star_valid = star_valid_q;
	assign star_count = star_count_q;

	`CSC_ASSERT_SAME(a_col_range, 1'b1, col_q <= col_t'(FRAME_WIDTH - 1), "column index out of range")
	`CSC_ASSERT_SAME(a_stall_cause, !pixel_ready, star_valid_q && frame_last, "pixel stall without pending count")
	`CSC_ASSERT_NEXT(a_frame_result, accept && frame_last, star_valid_q && count_q == '0, "frame end did not post count")
	`CSC_ASSERT_NEXT(a_count_hold, !accept, $stable(count_q) && $stable(col_q), "count or column moved without an item")

endmodule

FILE: tb/cross_stencil_star_counter_unit_checker.sv
// Checker for the star counter: predicts per-frame star counts and compares them.
module cross_stencil_star_counter_unit_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	input  logic                                pixel_ready,
	input  csc_pkg::pixel_t                     pixel,
	input  logic                                star_valid,
	input  logic                                star_ready,
	input  csc_pkg::count_t                     star_count,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [csc_pkg::ADDR_W-1:0]          paddr,
	input  logic [csc_pkg::DATA_W-1:0]          pwdata,
	input  logic [csc_pkg::DATA_W-1:0]          prdata,
	input  logic                                pready,
	input  logic                                run_done,
	output int                                  fail_count,
	output int                                  counts_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	localparam thresh_t THRESH_AT_RESET = thresh_t'(30);

	// stencil state: two rows of history plus the left neighbor of the middle row
	pixel_t  row_up2 [FRAME_WIDTH];
	pixel_t  row_up1 [FRAME_WIDTH];
	pixel_t  left_px;
	int      col_pos;
	int      row_pos;
	count_t  star_tally;
	thresh_t threshold;
	count_t  frame_counts[$];

	int      mismatches = 0;
	int      checked = 0;
	bit      drain_checked = 1'b0;
	count_t  oldest;

	assign fail_count     = mismatches;
	assign counts_checked = checked;

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// one accepted pixel: test the cross centered one row up, shift history
	task automatic take_pixel(input pixel_t px);
		int     cross_sum;
		pixel_t centre_px;
		pixel_t right_px;
		centre_px = row_up1[col_pos];
		right_px  = (col_pos + 1 < FRAME_WIDTH) ? row_up1[col_pos + 1] : '0;
		if (row_pos >= 2 && col_pos >= 1 && col_pos + 1 < FRAME_WIDTH) begin
			cross_sum = int'(left_px) + int'(centre_px) + int'(right_px)
				+ int'(row_up2[col_pos]) + int'(px);
			if (cross_sum > int'(threshold) && star_tally != COUNT_MAX)
				star_tally++;
		end
		row_up2[col_pos] = centre_px;
		row_up1[col_pos] = px;
		left_px = centre_px;
		if (col_pos + 1 < FRAME_WIDTH) begin
			col_pos++;
		end else begin
			col_pos = 0;
			left_px = '0;
			if (row_pos + 1 < FRAME_HEIGHT) begin
				row_pos++;
			end else begin
				row_pos = 0;
				frame_counts.push_back(star_tally);
				star_tally = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_WIDTH; i++) begin
				row_up2[i] = '0;
				row_up1[i] = '0;
			end
			left_px    = '0;
			col_pos    = 0;
			row_pos    = 0;
			star_tally = '0;
			threshold  = THRESH_AT_RESET;
			frame_counts.delete();
		end else begin
			// take results before pushing, so a same-edge frame end cannot mask one
			if (star_valid && star_ready) begin
				if (frame_counts.size() == 0) begin
					report($sformatf("star count %0d with no frame finished", star_count));
				end else begin
					oldest = frame_counts.pop_front();
					if (star_count !== oldest)
						report($sformatf("star count %0d, expected %0d", star_count, oldest));
					checked++;
				end
			end
			if (pixel_valid && pixel_ready)
				take_pixel(pixel);
			if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_THRESH) begin
				if (pwrite)
					threshold = thresh_t'(pwdata);
				else if (prdata[THRESH_W-1:0] !== threshold)
					report($sformatf("threshold read %0d, expected %0d",
						prdata[THRESH_W-1:0], threshold));
			end
			if (run_done && !drain_checked) begin
				drain_checked = 1'b1;
				if (frame_counts.size() != 0)
					report($sformatf("%0d star counts never came out", frame_counts.size()));
			end
		end
	end

endmodule

FILE: tb/cross_stencil_star_counter_unit_tb.sv
// Top of the star counter bench: clock, reset, pixel and register stimulus, verdict.
module cross_stencil_star_counter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csc_pkg::*;

	localparam int  PIXELS_PER_FRAME = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int  HOLD_CYCLES      = 10000;
	localparam int  RANDOM_PHASES    = 16;
	localparam logic REG_UNUSED      = 1'b1;

	typedef enum int {
		FILL_MAX,
		FILL_ZERO,
		NOISE_FULL,
		SPARSE_STARS,
		BRIGHT_FIELD,
		STRIPES
	} fill_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pixel_valid = 1'b0;
	logic                pixel_ready;
	pixel_t              pixel = '0;
	logic                star_valid;
	logic                star_ready = 1'b0;
	count_t              star_count;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                run_done = 1'b0;
	int                  fail_count;
	int                  counts_checked;

	bit sender_gaps = 1'b1;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int frames_sent = 0;
	int results_seen = 0;
	int thresh_writes = 0;

	always #4 clk = ~clk;

	cross_stencil_star_counter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.star_valid  (star_valid),
		.star_ready  (star_ready),
		.star_count  (star_count),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	cross_stencil_star_counter_unit_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_ready    (pixel_ready),
		.pixel          (pixel),
		.star_valid     (star_valid),
		.star_ready     (star_ready),
		.star_count     (star_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.run_done       (run_done),
		.fail_count     (fail_count),
		.counts_checked (counts_checked)
	);

	// count receiver: random stalls, a long hold-off on request, none when quiet
	initial begin : count_receiver
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (star_valid && star_ready)
				results_seen++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				star_ready <= 1'b0;
			end else if (quiet) begin
				star_ready <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				star_ready <= 1'b0;
			end else if ($urandom_range(3) == 0) begin
				idle_left = $urandom_range(1, 13) - 1;
				star_ready <= 1'b0;
			end else begin
				star_ready <= 1'b1;
			end
		end
	end

	task automatic reg_access(input logic wr, input logic idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write the threshold and read it back
	task automatic set_threshold(input logic [DATA_W-1:0] value);
		reg_access(1'b1, REG_THRESH, value);
		reg_access(1'b0, REG_THRESH, '0);
		thresh_writes++;
	endtask

	function automatic pixel_t make_pixel(input fill_t mode, input int idx);
		case (mode)
			FILL_MAX:     return '1;
			FILL_ZERO:    return '0;
			SPARSE_STARS: return ($urandom_range(49) == 0) ?
				pixel_t'($urandom_range(160, 255)) : pixel_t'($urandom_range(0, 12));
			BRIGHT_FIELD: return pixel_t'($urandom_range(100, 255));
			STRIPES:      return ((idx / FRAME_WIDTH) % 2 != 0) ?
				pixel_t'($urandom_range(200, 255)) : pixel_t'($urandom_range(0, 40));
			default:      return pixel_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input pixel_t p);
		if (sender_gaps && $urandom_range(15) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (!pixel_ready);
	endtask

	// stream whole frames, then wait for every count and let the block settle
	task automatic run_frames(input fill_t mode, input int n);
		for (int f = 0; f < n; f++) begin
			for (int i = 0; i < PIXELS_PER_FRAME; i++)
				send_pixel(make_pixel(mode, i));
			frames_sent++;
		end
		pixel_valid <= 1'b0;
		while (results_seen != frames_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [DATA_W-1:0] thr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold first
		run_frames(SPARSE_STARS, 1);
		// every interior pixel a star, then none
		set_threshold(0);
		run_frames(FILL_MAX, 1);
		run_frames(FILL_ZERO, 1);
		// saturated sum exactly at and just above the threshold
		set_threshold(1275);
		run_frames(FILL_MAX, 1);
		set_threshold(1274);
		run_frames(FILL_MAX, 1);
		// write to a nonexistent register must leave the threshold alone
		set_threshold(600);
		reg_access(1'b1, REG_UNUSED, '0);
		reg_access(1'b0, REG_THRESH, '0);
		run_frames(NOISE_FULL, 1);
		// upper data bits are dropped: low 11 bits give 700
		set_threshold(32'hFFFF_FABC);
		run_frames(NOISE_FULL, 1);
		set_threshold(32'h0000_07FF);
		run_frames(FILL_MAX, 1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(5))
				0:       thr = 0;
				1:       thr = 1275;
				2:       thr = 30;
				3:       thr = $urandom_range(560, 720);
				default: thr = $urandom_range(0, 1275);
			endcase
			set_threshold(thr);
			run_frames(fill_t'($urandom_range(NOISE_FULL, STRIPES)), $urandom_range(1, 2));
		end

		// count side held off long enough that the second frame end stalls the input
		set_threshold($urandom_range(560, 720));
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		run_frames(NOISE_FULL, 2);

		// closing stretch with no idling on either side
		quiet = 1'b1;
		set_threshold($urandom_range(0, 1275));
		run_frames(NOISE_FULL, 1);
		run_frames(SPARSE_STARS, 1);

		repeat (8) @(posedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);
		$display("Covered %0d frames (%0d pixels) over %0d threshold settings",
			frames_sent, frames_sent * PIXELS_PER_FRAME, thresh_writes);
		$display("Checked %0d star counts, including a long count-side stall", counts_checked);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
